### design/cv_modulated_hsl_to_rgb_macros.svh
// Assertion macros for the checker file of the HSL converter.
`ifndef CV_MODULATED_HSL_TO_RGB_MACROS_SVH
`define CV_MODULATED_HSL_TO_RGB_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is held.
`define CVHSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CVHSL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/cvhsl_pkg.sv
// Shared constants, types and width helpers of the HSL converter.
package cvhsl_pkg;

  localparam int CVHSL_FRAC_BITS = 12;

  localparam int CFG_W   = 13;
  localparam int VOLT_W  = 16;
  localparam int OUT_W   = 15;
  localparam int NUM_CH  = 4;
  localparam int NUM_OUT = 7;

  localparam int BASE_HUE_RST   = 455;
  localparam int BASE_SAT_RST   = 3482;
  localparam int BASE_LIGHT_RST = 2048;
  localparam int BASE_ALPHA_RST = 4096;

  localparam int STEPS_5V  = 10240;
  localparam int STEPS_10V = 20480;
  localparam int ROUND_10V = STEPS_10V / 2;

  // floor(n / 20480) = floor(floor(n / 4096) / 5); the divide by 5 is a
  // reciprocal multiply, exact for biased operands below 2**26.
  localparam int DIV5_PRESHIFT = 12;
  localparam int DIV5_RECIP    = 13421773;
  localparam int DIV5_SHIFT    = 26;
  localparam int DIV5_BIAS     = 1 << 20;
  localparam int DIV5_BIAS5    = 5 * DIV5_BIAS;

  localparam int MUL_MIN_W = 27;
  localparam int VAL_MIN_W = 17;

  typedef enum logic {
    MUL_QMUL,
    MUL_DIV5
  } mul_mode_t;

  typedef struct packed {
    logic      en;
    mul_mode_t mode;
  } mul_op_t;

  function automatic int mul_width(input int frac_bits);
    return (frac_bits + 4 > MUL_MIN_W) ? frac_bits + 4 : MUL_MIN_W;
  endfunction

  function automatic int val_width(input int frac_bits);
    return (frac_bits + 4 > VAL_MIN_W) ? frac_bits + 4 : VAL_MIN_W;
  endfunction

endpackage

### design/cvhsl_mul.sv
// Shared signed multiplier with registered product and rounding post-scale.
module cvhsl_mul import cvhsl_pkg::*; #(
  parameter int FRAC_BITS = CVHSL_FRAC_BITS,
  localparam int MW = mul_width(FRAC_BITS),
  localparam int VW = val_width(FRAC_BITS)
) (
  input  logic                 clk,
  input  mul_op_t              op,
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic signed [VW-1:0] res
);

  localparam int PW = 2 * MW;
  localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (FRAC_BITS - 1);

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] prod_nxt;
  mul_mode_t            mode_r;
  logic signed [PW-1:0] q_sum;
  logic signed [PW-1:0] q_shift;
  logic signed [PW-1:0] d_shift;

  assign prod_nxt = PW'(a) * PW'(b);

  always_ff @(posedge clk) begin
    if (op.en) begin
      prod_r <= prod_nxt;
      mode_r <= op.mode;
    end
  end

  // round half up for Q products, biased floor for the divide by five
  always_comb begin
    q_sum   = prod_r + HALF_P;
    q_shift = q_sum >>> FRAC_BITS;
    d_shift = (prod_r >>> DIV5_SHIFT) - PW'(DIV5_BIAS);
    case (mode_r)
      MUL_DIV5: res = VW'(d_shift);
      default:  res = VW'(q_shift);
    endcase
  end

endmodule

### design/cv_modulated_hsl_to_rgb.sv
// Top level of the CV-modulated HSL to RGB converter.
//
// One beat on the input channel carries four modulation voltages (hue,
// saturation, lightness, alpha; 2048 steps per volt) and a linked flag for
// each. A linked channel updates its sticky polarity detector (unipolar once
// above +5 V, bipolar once below 0 V), drops 5 V when unipolar, and adds
// volts/10 to its base register; hue wraps by one turn, the others clamp to
// 0..1. An unlinked channel passes its base value. The four values then go
// through the usual HSL to RGB scheme, and one output beat returns h, s, l,
// a, r, g, b as 0..10 V. The user must write the base registers on the cfg_
// port (index 0 hue, 1 saturation, 2 lightness, 3 alpha, 13-bit Q12 data)
// only while the block is idle; the block itself does not enforce it. One
// shared multiplier under a 16-step sequencer does all arithmetic (four
// divides by 20480, the l*s product, three color ramps and seven volt
// scalings); in_ready stays low from an accepted beat until its result is
// loaded into the output register, so no new beat is taken before the last
// is done. A finished result sits in the output register, and a stalled
// output holds only the final load, not the work on the next beat.
module cv_modulated_hsl_to_rgb import cvhsl_pkg::*; #(
  parameter int FRAC_BITS = CVHSL_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_hue_linked,
  input  logic                     in_sat_linked,
  input  logic                     in_light_linked,
  input  logic                     in_alpha_linked,
  input  logic signed [VOLT_W-1:0] in_hue_volts,
  input  logic signed [VOLT_W-1:0] in_sat_volts,
  input  logic signed [VOLT_W-1:0] in_light_volts,
  input  logic signed [VOLT_W-1:0] in_alpha_volts,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OUT_W-1:0]         out_hue_out,
  output logic [OUT_W-1:0]         out_sat_out,
  output logic [OUT_W-1:0]         out_light_out,
  output logic [OUT_W-1:0]         out_alpha_out,
  output logic [OUT_W-1:0]         out_red_out,
  output logic [OUT_W-1:0]         out_green_out,
  output logic [OUT_W-1:0]         out_blue_out
);

  localparam int MW = mul_width(FRAC_BITS);
  localparam int VW = val_width(FRAC_BITS);
  localparam int QB = FRAC_BITS + 1;
  localparam int AW = VOLT_W + 1;
  localparam int NW = AW + FRAC_BITS + 1;

  localparam logic signed [VW-1:0] ONE_V   = VW'(1) <<< FRAC_BITS;
  localparam logic signed [VW-1:0] TWO_V   = ONE_V <<< 1;
  localparam logic signed [VW-1:0] THREE_V = TWO_V + ONE_V;
  localparam logic signed [VW-1:0] FOUR_V  = ONE_V <<< 2;
  localparam logic [QB-1:0]        ONE_Q   = QB'(1) << FRAC_BITS;
  localparam logic [1:0]           CH_HUE  = 2'd0;

  typedef enum logic [1:0] {
    CFG_BASE_HUE,
    CFG_BASE_SAT,
    CFG_BASE_LIGHT,
    CFG_BASE_ALPHA
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // each step but S_LAST names the product it issues; each but the first takes the previous one
  typedef enum logic [3:0] {
    S_DIV_H, S_DIV_S, S_DIV_L, S_DIV_A,
    S_LS,    S_TV_H,  S_CH_R,  S_CH_G,
    S_CH_B,  S_TV_S,  S_TV_L,  S_TV_A,
    S_TV_R,  S_TV_G,  S_TV_B,  S_LAST
  } step_t;

  state_t                  state_r, state_nxt;
  step_t                   step_r, step_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [CFG_W-1:0]        base_r [NUM_CH];
  logic [CFG_W-1:0]        base_nxt [NUM_CH];
  logic                    uni_r [NUM_CH];
  logic                    uni_nxt [NUM_CH];
  logic                    lnk_r [NUM_CH];
  logic                    lnk_nxt [NUM_CH];
  logic signed [AW-1:0]    vadj_r [NUM_CH];
  logic signed [AW-1:0]    vadj_nxt [NUM_CH];
  logic [QB-1:0]           q_r [NUM_CH];
  logic [QB-1:0]           q_nxt [NUM_CH];
  logic signed [VW-1:0]    m1_r, m1_nxt, m2_r, m2_nxt;
  logic signed [VW-1:0]    ch_r [3];
  logic signed [VW-1:0]    ch_nxt [3];
  logic [OUT_W-1:0]        vol_r [NUM_OUT];
  logic [OUT_W-1:0]        vol_nxt [NUM_OUT];
  logic [OUT_W-1:0]        out_r [NUM_OUT];
  logic [OUT_W-1:0]        out_nxt [NUM_OUT];

  logic signed [VOLT_W-1:0] in_v [NUM_CH];
  logic                     in_l [NUM_CH];

  mul_op_t                 mul_op;
  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [VW-1:0]    mres;

  logic [1:0]              cap_idx;
  logic [QB-1:0]           base_c;
  logic signed [VW-1:0]    sum_w;
  logic [QB-1:0]           mod_q;
  logic signed [VW-1:0]    l_v, s_v, l2_v;

  logic signed [AW-1:0]    sel_v;
  logic signed [NW-1:0]    n_w, mp_w;
  logic signed [VW-1:0]    tv_src;
  logic [QB-1:0]           tv_q;
  logic signed [VW-1:0]    hh_v, off_v, h3_v, tw_v, x_v;

  function automatic logic [QB-1:0] clamp1(input logic signed [VW-1:0] x);
    logic [QB-1:0] r;
    if (x < 0) r = '0;
    else if (x > ONE_V) r = ONE_Q;
    else r = x[QB-1:0];
    return r;
  endfunction

  function automatic logic signed [VW-1:0] hue_wrap(input logic signed [VW-1:0] x);
    logic signed [VW-1:0] r;
    if (x < 0) r = x + ONE_V;
    else if (x > ONE_V) r = x - ONE_V;
    else r = x;
    return r;
  endfunction

  assign in_v[0] = in_hue_volts;
  assign in_v[1] = in_sat_volts;
  assign in_v[2] = in_light_volts;
  assign in_v[3] = in_alpha_volts;
  assign in_l[0] = in_hue_linked;
  assign in_l[1] = in_sat_linked;
  assign in_l[2] = in_light_linked;
  assign in_l[3] = in_alpha_linked;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  assign out_hue_out   = out_r[0];
  assign out_sat_out   = out_r[1];
  assign out_light_out = out_r[2];
  assign out_alpha_out = out_r[3];
  assign out_red_out   = out_r[4];
  assign out_green_out = out_r[5];
  assign out_blue_out  = out_r[6];

  cvhsl_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk (clk),
    .op  (mul_op),
    .a   (mul_a),
    .b   (mul_b),
    .res (mres)
  );

  // ---------------------------------------------------------------------
  // Operand side: pick what the shared multiplier works on this step
  // ---------------------------------------------------------------------

  // delta = floor((v * ONE + 10240) / 20480): shift, add, then divide by
  // five with a positive bias so the reciprocal multiply stays exact
  always_comb begin
    sel_v = vadj_r[step_r[1:0]];
    n_w   = (NW'(sel_v) <<< FRAC_BITS) + NW'(ROUND_10V);
    mp_w  = (n_w >>> DIV5_PRESHIFT) + NW'(DIV5_BIAS5);
  end

  // color ramp input: hue times three, offset per component, wrapped
  // into 0..3, then folded to the ramp weight; the flat top uses weight
  // one so the same multiply returns m2 exactly
  always_comb begin
    hh_v = (q_r[0] >= ONE_Q) ? '0 : VW'(q_r[0]);
    case (step_r)
      S_CH_R:  off_v = ONE_V;
      S_CH_B:  off_v = -ONE_V;
      default: off_v = '0;
    endcase
    h3_v = (hh_v <<< 1) + hh_v + off_v;
    if (h3_v < 0) h3_v = h3_v + THREE_V;
    else if (h3_v > THREE_V) h3_v = h3_v - THREE_V;
    tw_v = h3_v <<< 1;
    if (tw_v < ONE_V) x_v = tw_v;
    else if (tw_v < THREE_V) x_v = ONE_V;
    else if (h3_v < TWO_V) x_v = FOUR_V - tw_v;
    else x_v = '0;
  end

  always_comb begin
    case (step_r)
      S_TV_H:  tv_src = VW'(q_r[0]);
      S_TV_S:  tv_src = VW'(q_r[1]);
      S_TV_L:  tv_src = VW'(q_r[2]);
      S_TV_A:  tv_src = VW'(q_r[3]);
      S_TV_R:  tv_src = ch_r[0];
      S_TV_G:  tv_src = ch_r[1];
      S_TV_B:  tv_src = ch_r[2];
      default: tv_src = '0;
    endcase
    tv_q = clamp1(tv_src);
  end

  always_comb begin
    mul_op.en   = (state_r == ST_RUN) && (step_r != S_LAST);
    mul_op.mode = MUL_QMUL;
    mul_a       = '0;
    mul_b       = '0;
    case (step_r)
      S_DIV_H, S_DIV_S, S_DIV_L, S_DIV_A: begin
        mul_op.mode = MUL_DIV5;
        mul_a       = MW'(mp_w);
        mul_b       = MW'(DIV5_RECIP);
      end
      S_LS: begin
        mul_a = MW'(q_r[2]);
        mul_b = MW'(q_r[1]);
      end
      S_CH_R, S_CH_G, S_CH_B: begin
        mul_a = MW'(m2_r - m1_r);
        mul_b = MW'(x_v);
      end
      S_TV_H, S_TV_S, S_TV_L, S_TV_A, S_TV_R, S_TV_G, S_TV_B: begin
        mul_a = MW'(tv_q);
        mul_b = MW'(STEPS_10V);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Result side: fold the previous product into the working registers
  // ---------------------------------------------------------------------

  // base plus delta for the channel whose divide finished last step
  always_comb begin
    cap_idx = 2'(step_r - 4'd1);
    base_c  = clamp1(VW'(base_r[cap_idx]));
    sum_w   = VW'(base_c) + mres;
    if (!lnk_r[cap_idx]) mod_q = base_c;
    else if (cap_idx == CH_HUE) mod_q = clamp1(hue_wrap(sum_w));
    else mod_q = clamp1(sum_w);
  end

  assign l_v  = VW'(q_r[2]);
  assign s_v  = VW'(q_r[1]);
  assign l2_v = l_v <<< 1;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    base_nxt      = base_r;
    uni_nxt       = uni_r;
    lnk_nxt       = lnk_r;
    vadj_nxt      = vadj_r;
    q_nxt         = q_r;
    m1_nxt        = m1_r;
    m2_nxt        = m2_r;
    ch_nxt        = ch_r;
    vol_nxt       = vol_r;
    out_nxt       = out_r;

    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BASE_HUE:   base_nxt[0] = cfg_data;
        CFG_BASE_SAT:   base_nxt[1] = cfg_data;
        CFG_BASE_LIGHT: base_nxt[2] = cfg_data;
        CFG_BASE_ALPHA: base_nxt[3] = cfg_data;
        default:        base_nxt[0] = base_r[0];
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // update the sticky detectors and drop 5 V from unipolar inputs
          for (int k = 0; k < NUM_CH; k++) begin
            if (in_l[k]) begin
              if (in_v[k] < 0) uni_nxt[k] = 1'b0;
              else if (in_v[k] > STEPS_5V) uni_nxt[k] = 1'b1;
            end
            vadj_nxt[k] = uni_nxt[k] ? AW'(in_v[k]) - AW'(STEPS_5V) : AW'(in_v[k]);
            lnk_nxt[k]  = in_l[k];
          end
          state_nxt = ST_RUN;
          step_nxt  = S_DIV_H;
        end
      end
      ST_RUN: begin
        step_nxt = step_t'(step_r + 4'd1);
        if (step_r == S_LAST) state_nxt = ST_DONE;
        case (step_r)
          S_DIV_S, S_DIV_L, S_DIV_A, S_LS: q_nxt[cap_idx] = mod_q;
          S_TV_H: begin
            if (l2_v <= ONE_V) m2_nxt = l_v + mres;
            else m2_nxt = l_v + s_v - mres;
            m1_nxt = l2_v - m2_nxt;
          end
          S_CH_R: vol_nxt[0] = OUT_W'(mres);
          S_CH_G: ch_nxt[0]  = m1_r + mres;
          S_CH_B: ch_nxt[1]  = m1_r + mres;
          S_TV_S: ch_nxt[2]  = m1_r + mres;
          S_TV_L: vol_nxt[1] = OUT_W'(mres);
          S_TV_A: vol_nxt[2] = OUT_W'(mres);
          S_TV_R: vol_nxt[3] = OUT_W'(mres);
          S_TV_G: vol_nxt[4] = OUT_W'(mres);
          S_TV_B: vol_nxt[5] = OUT_W'(mres);
          S_LAST: vol_nxt[6] = OUT_W'(mres);
          default: m1_nxt = m1_r;
        endcase
      end
      ST_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_nxt       = vol_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= S_DIV_H;
      out_valid_r <= 1'b0;
      base_r[0]   <= CFG_W'(BASE_HUE_RST);
      base_r[1]   <= CFG_W'(BASE_SAT_RST);
      base_r[2]   <= CFG_W'(BASE_LIGHT_RST);
      base_r[3]   <= CFG_W'(BASE_ALPHA_RST);
      for (int k = 0; k < NUM_CH; k++) uni_r[k] <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      base_r      <= base_nxt;
      uni_r       <= uni_nxt;
    end
    lnk_r  <= lnk_nxt;
    vadj_r <= vadj_nxt;
    q_r    <= q_nxt;
    m1_r   <= m1_nxt;
    m2_r   <= m2_nxt;
    ch_r   <= ch_nxt;
    vol_r  <= vol_nxt;
    out_r  <= out_nxt;
  end

endmodule

### design/cvhsl_checker.sv
// Port-level checker of the HSL converter, bound to the top level.
`include "cv_modulated_hsl_to_rgb_macros.svh"

module cvhsl_checker import cvhsl_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_hue_out,
  input logic [OUT_W-1:0] out_red_out,
  input logic [OUT_W-1:0] out_green_out,
  input logic [OUT_W-1:0] out_blue_out
);

  `CVHSL_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && in_ready, "not idle after reset")

  `CVHSL_ASSERT(a_busy_after_beat, in_valid && in_ready |=> !in_ready, "input taken while busy")

  `CVHSL_ASSERT(a_no_instant_result, in_valid && in_ready |=> !$rose(out_valid), "result too soon")

  `CVHSL_ASSERT(a_volt_range, out_valid |-> (out_hue_out <= OUT_W'(STEPS_10V)) && (out_red_out <= OUT_W'(STEPS_10V)) && (out_green_out <= OUT_W'(STEPS_10V)) && (out_blue_out <= OUT_W'(STEPS_10V)), "output above 10 V")

  `CVHSL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_red_out) && $stable(out_blue_out), "stalled result changed")

endmodule

bind cv_modulated_hsl_to_rgb cvhsl_checker u_cvhsl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_hue_out   (out_hue_out),
  .out_red_out   (out_red_out),
  .out_green_out (out_green_out),
  .out_blue_out  (out_blue_out)
);

### sim/testbench.sv
// Self-checking testbench for the CV-modulated HSL to RGB converter.
`timescale 1ns / 100ps

module testbench;
  import cvhsl_pkg::*;

  // Base register indexes on the cfg_ port.
  localparam logic [1:0] REG_BASE_HUE   = 2'd0;
  localparam logic [1:0] REG_BASE_SAT   = 2'd1;
  localparam logic [1:0] REG_BASE_LIGHT = 2'd2;
  localparam logic [1:0] REG_BASE_ALPHA = 2'd3;

  localparam longint UNIT        = longint'(1) << CVHSL_FRAC_BITS;
  localparam int     VOLT_MAX    = 24576;
  localparam int     CFG_MAX     = (1 << CFG_W) - 1;
  localparam int     CYCLE_LIMIT = 300000;
  localparam int     LONG_HOLD   = 300;
  localparam int     PHASE_BEATS = 260;

  // One control sample: link flags and the four modulation voltages.
  typedef struct packed {
    logic                     hue_linked;
    logic                     sat_linked;
    logic                     light_linked;
    logic                     alpha_linked;
    logic signed [VOLT_W-1:0] hue_volts;
    logic signed [VOLT_W-1:0] sat_volts;
    logic signed [VOLT_W-1:0] light_volts;
    logic signed [VOLT_W-1:0] alpha_volts;
  } cv_beat_t;

  // One output beat: h, s, l, a and the converted r, g, b, all as 0..10 V.
  typedef struct packed {
    logic [OUT_W-1:0] hue;
    logic [OUT_W-1:0] sat;
    logic [OUT_W-1:0] light;
    logic [OUT_W-1:0] alpha;
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } colors_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [1:0]               cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_hue_linked;
  logic                     in_sat_linked;
  logic                     in_light_linked;
  logic                     in_alpha_linked;
  logic signed [VOLT_W-1:0] in_hue_volts;
  logic signed [VOLT_W-1:0] in_sat_volts;
  logic signed [VOLT_W-1:0] in_light_volts;
  logic signed [VOLT_W-1:0] in_alpha_volts;
  logic                     out_valid;
  logic                     out_ready;
  logic [OUT_W-1:0]         out_hue_out;
  logic [OUT_W-1:0]         out_sat_out;
  logic [OUT_W-1:0]         out_light_out;
  logic [OUT_W-1:0]         out_alpha_out;
  logic [OUT_W-1:0]         out_red_out;
  logic [OUT_W-1:0]         out_green_out;
  logic [OUT_W-1:0]         out_blue_out;

  // Shadow copy of the block: base registers and sticky polarity flags.
  logic [CFG_W-1:0] base_q [4];
  bit               hue_uni, sat_uni, light_uni, alpha_uni;

  colors_t expected_colors [$];

  int  error_count     = 0;
  int  beat_count      = 0;
  int  result_count    = 0;
  int  setting_count   = 0;
  int  cycle_count     = 0;
  int  hold_off_cycles = 0;
  bit  idle_on         = 1'b1;

  cv_modulated_hsl_to_rgb dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_hue_linked   (in_hue_linked),
    .in_sat_linked   (in_sat_linked),
    .in_light_linked (in_light_linked),
    .in_alpha_linked (in_alpha_linked),
    .in_hue_volts    (in_hue_volts),
    .in_sat_volts    (in_sat_volts),
    .in_light_volts  (in_light_volts),
    .in_alpha_volts  (in_alpha_volts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hue_out     (out_hue_out),
    .out_sat_out     (out_sat_out),
    .out_light_out   (out_light_out),
    .out_alpha_out   (out_alpha_out),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_colors.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Color predictor
  // ---------------------------------------------------------------------

  // Division that rounds toward minus infinity, as the block's math does.
  function automatic longint floor_div(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  // Round to nearest, halves toward plus infinity.
  function automatic longint round_div(input longint n, input longint d);
    return floor_div(n + d / 2, d);
  endfunction

  function automatic longint clamp_unit(input longint x);
    if (x < 0) return 0;
    if (x > UNIT) return UNIT;
    return x;
  endfunction

  // Scale a Q fraction to 0..10 V steps.
  function automatic logic [OUT_W-1:0] frac_to_volts(input longint x);
    longint v;
    v = round_div(clamp_unit(x) * STEPS_10V, UNIT);
    return v[OUT_W-1:0];
  endfunction

  // One color ramp; h3 is three times the hue.
  function automatic longint color_ramp(input longint h3, input longint m1,
                                        input longint m2);
    longint turn3;
    turn3 = 3 * UNIT;
    if (h3 < 0) h3 += turn3;
    if (h3 > turn3) h3 -= turn3;
    if (2 * h3 < UNIT) return m1 + round_div((m2 - m1) * (2 * h3), UNIT);
    if (2 * h3 < turn3) return m2;
    if (h3 < 2 * UNIT) return m1 + round_div((m2 - m1) * (4 * UNIT - 2 * h3), UNIT);
    return m1;
  endfunction

  // Update the sticky detector of a linked channel and form base + volts/10.
  // An unlinked channel keeps its detector and passes the saturated base.
  task automatic modulate_channel(input longint base, input logic linked,
                                  input longint volts, inout bit uni,
                                  output longint sum);
    longint v;
    v   = volts;
    sum = clamp_unit(base);
    if (linked) begin
      if (v < 0) uni = 1'b0;
      else if (v > STEPS_5V) uni = 1'b1;
      if (uni) v -= STEPS_5V;
      sum += round_div(v * UNIT, STEPS_10V);
    end
  endtask

  // Work out the result of one accepted beat and queue it.
  task automatic predict_colors(input cv_beat_t beat);
    longint  h, s, l, a, hh, m1, m2;
    colors_t c;
    modulate_channel(longint'(base_q[REG_BASE_HUE]), beat.hue_linked,
                     longint'($signed(beat.hue_volts)), hue_uni, h);
    modulate_channel(longint'(base_q[REG_BASE_SAT]), beat.sat_linked,
                     longint'($signed(beat.sat_volts)), sat_uni, s);
    modulate_channel(longint'(base_q[REG_BASE_LIGHT]), beat.light_linked,
                     longint'($signed(beat.light_volts)), light_uni, l);
    modulate_channel(longint'(base_q[REG_BASE_ALPHA]), beat.alpha_linked,
                     longint'($signed(beat.alpha_volts)), alpha_uni, a);
    // Hue wraps by one turn, then everything clamps to 0..1.
    if (h < 0) h += UNIT;
    else if (h > UNIT) h -= UNIT;
    h = clamp_unit(h);
    s = clamp_unit(s);
    l = clamp_unit(l);
    a = clamp_unit(a);
    // A full turn reads as zero in the conversion only.
    hh = (h >= UNIT) ? h - UNIT : h;
    if (2 * l <= UNIT) m2 = l + round_div(l * s, UNIT);
    else m2 = l + s - round_div(l * s, UNIT);
    m1 = 2 * l - m2;
    c.hue   = frac_to_volts(h);
    c.sat   = frac_to_volts(s);
    c.light = frac_to_volts(l);
    c.alpha = frac_to_volts(a);
    c.red   = frac_to_volts(color_ramp(3 * hh + UNIT, m1, m2));
    c.green = frac_to_volts(color_ramp(3 * hh, m1, m2));
    c.blue  = frac_to_volts(color_ramp(3 * hh - UNIT, m1, m2));
    expected_colors.push_back(c);
  endtask

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offer one beat, after a random gap when idling is on; hold valid until it is taken.
  task automatic send_beat(input cv_beat_t beat);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_hue_linked   <= beat.hue_linked;
    in_sat_linked   <= beat.sat_linked;
    in_light_linked <= beat.light_linked;
    in_alpha_linked <= beat.alpha_linked;
    in_hue_volts    <= beat.hue_volts;
    in_sat_volts    <= beat.sat_volts;
    in_light_volts  <= beat.light_volts;
    in_alpha_volts  <= beat.alpha_volts;
    do @(posedge clk); while (!in_ready);
    predict_colors(beat);
    beat_count++;
  endtask

  // Drop valid and hold until every queued result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
  endtask

  // Write all four base registers back to back; call only when idle.
  task automatic program_bases(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] s,
                               input logic [CFG_W-1:0] l, input logic [CFG_W-1:0] a);
    logic [CFG_W-1:0] vals [4];
    vals[REG_BASE_HUE]   = h;
    vals[REG_BASE_SAT]   = s;
    vals[REG_BASE_LIGHT] = l;
    vals[REG_BASE_ALPHA] = a;
    for (int r = REG_BASE_HUE; r <= REG_BASE_ALPHA; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= r[1:0];
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      base_q[r] = vals[r];
    end
    cfg_valid <= 1'b0;
    setting_count++;
  endtask

  function automatic cv_beat_t make_beat(input logic [3:0] links, input int hv,
                                         input int sv, input int lv, input int av);
    cv_beat_t b;
    {b.hue_linked, b.sat_linked, b.light_linked, b.alpha_linked} = links;
    b.hue_volts   = hv[VOLT_W-1:0];
    b.sat_volts   = sv[VOLT_W-1:0];
    b.light_volts = lv[VOLT_W-1:0];
    b.alpha_volts = av[VOLT_W-1:0];
    return b;
  endfunction

  // Voltages weighted toward the detector thresholds and the range ends.
  function automatic int random_volts();
    case ($urandom_range(0, 5))
      0, 1:    return int'($urandom_range(0, 2 * VOLT_MAX)) - VOLT_MAX;
      2:       return STEPS_5V - 2 + int'($urandom_range(0, 4));
      3:       return int'($urandom_range(0, 2)) - 1;
      4:       return $urandom_range(0, 1) ? VOLT_MAX : -VOLT_MAX;
      default: return int'($urandom_range(0, 4096)) - 2048;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_base();
    int v;
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = int'(UNIT);
      2:       v = CFG_MAX;
      3, 4:    v = $urandom_range(0, int'(UNIT));
      default: v = $urandom_range(0, CFG_MAX);
    endcase
    return v[CFG_W-1:0];
  endfunction

  function automatic cv_beat_t random_beat();
    logic [3:0] links;
    for (int i = 0; i < 4; i++) links[i] = ($urandom_range(0, 3) != 0);
    return make_beat(links, random_volts(), random_volts(), random_volts(),
                     random_volts());
  endfunction

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Compare one output beat with the oldest expectation.
  task automatic check_colors(input colors_t got);
    colors_t want;
    if (expected_colors.size() == 0) begin
      $display("%0t: result beat with nothing expected, expected none, got h=%0d",
               $time, got.hue);
      error_count++;
    end else begin
      want = expected_colors.pop_front();
      check_field("hue_out",   want.hue,   got.hue);
      check_field("sat_out",   want.sat,   got.sat);
      check_field("light_out", want.light, got.light);
      check_field("alpha_out", want.alpha, got.alpha);
      check_field("red_out",   want.red,   got.red);
      check_field("green_out", want.green, got.green);
      check_field("blue_out",  want.blue,  got.blue);
    end
    result_count++;
  endtask

  // Receiver: stall a random number of cycles per beat while idling is on, or a
  // long stretch when a test asks for it, then take the next result.
  initial begin : result_sink
    int      stall;
    colors_t got;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 4) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{out_hue_out, out_sat_out, out_light_out, out_alpha_out,
              out_red_out, out_green_out, out_blue_out};
      check_colors(got);
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset bases pass through when unlinked; zero volts leave them alone.
  task automatic test_passthrough();
    send_beat(make_beat(4'b0000, -VOLT_MAX, VOLT_MAX, -1, 1));
    send_beat(make_beat(4'b1111, 0, 0, 0, 0));
    wait_drained();
  endtask

  // Walk the sticky detector through both thresholds on all channels.
  task automatic test_polarity_detector();
    int steps [8] = '{-VOLT_MAX, VOLT_MAX, STEPS_5V, 0, -1, STEPS_5V,
                      STEPS_5V + 1, VOLT_MAX};
    foreach (steps[i]) send_beat(make_beat(4'b1111, steps[i], steps[i],
                                           steps[i], steps[i]));
    // Unlinked hue must keep its unipolar flag through a negative voltage.
    send_beat(make_beat(4'b0111, -VOLT_MAX, -VOLT_MAX, -VOLT_MAX, -VOLT_MAX));
    send_beat(make_beat(4'b1111, 5000, 5000, 5000, 5000));
    wait_drained();
  endtask

  // Hue below zero and above one turn, and a hue of exactly one turn.
  task automatic test_hue_wrap();
    program_bases(0, BASE_SAT_RST, BASE_LIGHT_RST, BASE_ALPHA_RST);
    send_beat(make_beat(4'b1100, -2048, 3000, 0, 0));
    wait_drained();
    program_bases(CFG_W'(UNIT), BASE_SAT_RST, BASE_LIGHT_RST, BASE_ALPHA_RST);
    send_beat(make_beat(4'b1000, 2048, 0, 0, 0));
    send_beat(make_beat(4'b0000, 0, 0, 0, 0));
    send_beat(make_beat(4'b1010, 0, 0, -4000, 0));
    wait_drained();
  endtask

  // Bases above one saturate; all-zero bases give black.
  task automatic test_base_extremes();
    program_bases(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
    send_beat(make_beat(4'b0000, 0, 0, 0, 0));
    send_beat(make_beat(4'b1111, -2048, -2048, -2048, -2048));
    wait_drained();
    program_bases(0, 0, 0, 0);
    send_beat(make_beat(4'b0000, 0, 0, 0, 0));
    send_beat(make_beat(4'b1111, VOLT_MAX, VOLT_MAX, VOLT_MAX, VOLT_MAX));
    wait_drained();
  endtask

  // Hold the output off long enough that the block must stall its input.
  task automatic test_backpressure();
    program_bases(random_base(), random_base(), random_base(), random_base());
    hold_off_cycles = LONG_HOLD;
    repeat (40) send_beat(random_beat());
    wait_drained();
  endtask

  // Random phases, each under fresh base settings; one phase runs with
  // no idling on either side.
  task automatic test_random_phases();
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      program_bases(random_base(), random_base(), random_base(), random_base());
      idle_on = (p != 1);
      repeat (PHASE_BEATS) send_beat(random_beat());
    end
    idle_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    base_q[REG_BASE_HUE]   = BASE_HUE_RST;
    base_q[REG_BASE_SAT]   = BASE_SAT_RST;
    base_q[REG_BASE_LIGHT] = BASE_LIGHT_RST;
    base_q[REG_BASE_ALPHA] = BASE_ALPHA_RST;
    rst_n           <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_BASE_HUE;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    in_hue_linked   <= 1'b0;
    in_sat_linked   <= 1'b0;
    in_light_linked <= 1'b0;
    in_alpha_linked <= 1'b0;
    in_hue_volts    <= '0;
    in_sat_volts    <= '0;
    in_light_volts  <= '0;
    in_alpha_volts  <= '0;
    out_ready       <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_passthrough();
    test_polarity_detector();
    test_hue_wrap();
    test_base_extremes();
    test_backpressure();
    test_random_phases();

    // Let any stray beat show up before judging.
    wait_drained();
    repeat (40) @(posedge clk);

    $display("Sent %0d samples, checked %0d result beats over %0d base settings,",
             beat_count, result_count, setting_count);
    $display("with detector flips, hue wrap both ways, saturated bases and a long stall.");
    if (error_count == 0 && expected_colors.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               error_count, expected_colors.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/cvhsl_pkg.sv
design/cvhsl_mul.sv
design/cv_modulated_hsl_to_rgb.sv
design/cvhsl_checker.sv
sim/testbench.sv
